### rtl/proportional_glyph_blitter_macros.svh
// Assertion macros used by the blitter engine RTL
`ifndef PROPORTIONAL_GLYPH_BLITTER_MACROS_SVH
`define PROPORTIONAL_GLYPH_BLITTER_MACROS_SVH

// same-cycle implication, sampled on clk, off during rst
`define PGB_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication, sampled on clk, off during rst
`define PGB_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

### rtl/pgb_pkg.sv
// Package: types, constants and helper functions of the glyph blitter
package pgb_pkg;

  localparam int PGB_ADDR_BITS = 14;
  localparam int GLYPHS        = 96;
  localparam int GLYPH_ROWS    = 8;
  localparam int FONT_DEPTH    = GLYPHS * GLYPH_ROWS;
  localparam int FONT_AW       = $clog2(FONT_DEPTH);
  localparam int GIDX_W        = FONT_AW - 3;

  localparam logic [7:0] CODE_LO    = 8'd32;
  localparam logic [7:0] CODE_HI    = 8'd127;
  localparam logic [7:0] CODE_DOT   = 8'h2e;
  localparam logic [7:0] BLANK_MASK = 8'hfc;

  localparam logic [2:0] REG_WIN_X  = 3'd0;
  localparam logic [2:0] REG_WIN_Y  = 3'd1;
  localparam logic [2:0] REG_WIN_W  = 3'd2;
  localparam logic [2:0] REG_WIN_H  = 3'd3;
  localparam logic [2:0] REG_SCR_W  = 3'd4;
  localparam logic [2:0] REG_SCR_H  = 3'd5;
  localparam logic [2:0] REG_STRIDE = 3'd6;

  localparam logic [7:0] RST_WIN_X  = 8'd0;
  localparam logic [7:0] RST_WIN_Y  = 8'd0;
  localparam logic [7:0] RST_WIN_W  = 8'd32;
  localparam logic [7:0] RST_WIN_H  = 8'd24;
  localparam logic [7:0] RST_SCR_W  = 8'd32;
  localparam logic [7:0] RST_SCR_H  = 8'd24;
  localparam logic [7:0] RST_STRIDE = 8'd32;

  localparam logic REQ_LOAD = 1'b0;
  localparam logic REQ_DRAW = 1'b1;

  typedef struct packed {
    logic [7:0] win_x;
    logic [7:0] win_y;
    logic [7:0] win_w;
    logic [7:0] win_h;
    logic [7:0] scr_w;
    logic [7:0] scr_h;
    logic [7:0] stride;
  } pgb_cfg_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MASK,
    ST_MASK_WAIT,
    ST_SHAPE,
    ST_EMIT_L,
    ST_EMIT_R
  } pgb_state_t;

  function automatic logic code_in_range(logic [7:0] code);
    return code inside {[CODE_LO:CODE_HI]};
  endfunction

  function automatic logic [GIDX_W-1:0] glyph_index(logic [7:0] code);
    logic [7:0] idx;
    idx = code - CODE_LO;
    return idx[GIDX_W-1:0];
  endfunction

  // smallest shift leaving at most one blank leading column
  function automatic logic [2:0] lead_shift(logic [7:0] m);
    logic [2:0] ls;
    ls = 3'd7;
    for (int s = 6; s >= 0; s--) begin
      if (m[7-s] || m[6-s]) begin
        ls = 3'(s);
      end
    end
    return ls;
  endfunction

  function automatic logic [2:0] trail_zeros(logic [7:0] m);
    logic [2:0] tz;
    tz = 3'd0;
    for (int i = 7; i >= 0; i--) begin
      if (m[i]) begin
        tz = 3'(i);
      end
    end
    return tz;
  endfunction

  function automatic logic [7:0] smear(logic [7:0] m);
    return m | {m[6:0], 1'b0};
  endfunction

endpackage

### rtl/pgb_ram.sv
// Generic single-write, single-read RAM with registered read data
module pgb_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 768
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

### rtl/pgb_regs.sv
// Configuration register file of the glyph blitter
module pgb_regs import pgb_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  logic [2:0] cfg_index,
  input  logic [7:0] cfg_data,
  output pgb_cfg_t   cfg
);

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.win_x  <= RST_WIN_X;
      cfg.win_y  <= RST_WIN_Y;
      cfg.win_w  <= RST_WIN_W;
      cfg.win_h  <= RST_WIN_H;
      cfg.scr_w  <= RST_SCR_W;
      cfg.scr_h  <= RST_SCR_H;
      cfg.stride <= RST_STRIDE;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_WIN_X:  cfg.win_x  <= cfg_data;
        REG_WIN_Y:  cfg.win_y  <= cfg_data;
        REG_WIN_W:  cfg.win_w  <= cfg_data;
        REG_WIN_H:  cfg.win_h  <= cfg_data;
        REG_SCR_W:  cfg.scr_w  <= cfg_data;
        REG_SCR_H:  cfg.scr_h  <= cfg_data;
        REG_STRIDE: cfg.stride <= cfg_data;
        default: begin
        end
      endcase
    end
  end

endmodule

### rtl/pgb_engine.sv
// Draw sequencer: font reads, mask shaping, clipping and command emission
`include "proportional_glyph_blitter_macros.svh"

module pgb_engine import pgb_pkg::*; #(
  parameter int ADDR_BITS = PGB_ADDR_BITS
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 start,
  input  logic                 req_type,
  input  logic [7:0]           char_code,
  input  logic [10:0]          x_pixel,
  input  logic [7:0]           y_cell,
  input  logic                 bold,
  input  pgb_cfg_t             cfg,
  input  logic [7:0]           rdata,
  output logic [FONT_AW-1:0]   raddr,
  output logic                 busy,
  output logic                 result_valid,
  output logic                 write_enable,
  output logic [ADDR_BITS-1:0] byte_address,
  output logic [7:0]           and_mask,
  output logic [7:0]           or_bits,
  output logic [3:0]           glyph_width,
  output logic                 last
);

  pgb_state_t state, state_next;

  logic [2:0]           row;
  logic [GIDX_W-1:0]    base;
  logic [2:0]           rs;
  logic [7:0]           cx;
  logic [7:0]           y_cell_r;
  logic                 bold_r;
  logic [7:0]           mask;
  logic [15:0]          mw;
  logic [3:0]           sh;
  logic [3:0]           width;
  logic [ADDR_BITS-1:0] row_addr;
  logic                 left_ok;
  logic                 right_ok;
  logic [7:0]           right_or;

  logic                 draw_acc;
  logic [2:0]           rd_row;
  logic [8:0]           yy;
  logic [8:0]           xc;
  logic [8:0]           ylim;
  logic [8:0]           xlim;
  logic [19:0]          prod;
  logic [7:0]           mask_eff;
  logic [7:0]           mask_b;
  logic [2:0]           ls;
  logic [2:0]           tz;
  logic [3:0]           width_base;
  logic [3:0]           sh_next;
  logic [15:0]          mw_next;
  logic [7:0]           p;
  logic [15:0]          pw;

  assign draw_acc = start && !busy && (req_type == REQ_DRAW);
  assign raddr    = {base, rd_row};

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    busy       = 1'b1;
    rd_row     = row + 3'd1;
    case (state)
      ST_IDLE: begin
        busy = 1'b0;
        if (draw_acc) begin
          state_next = ST_MASK;
        end
      end
      ST_MASK: begin
        rd_row = row;
        if (row == 3'd7) begin
          state_next = ST_MASK_WAIT;
        end
      end
      ST_MASK_WAIT: begin
        state_next = ST_SHAPE;
      end
      ST_SHAPE: begin
        rd_row     = row;
        state_next = ST_EMIT_L;
      end
      ST_EMIT_L: begin
        if (rs != 3'd0) begin
          state_next = ST_EMIT_R;
        end else if (row == 3'd7) begin
          state_next = ST_IDLE;
        end
      end
      ST_EMIT_R: begin
        state_next = (row == 3'd7) ? ST_IDLE : ST_EMIT_L;
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    yy         = {1'b0, cfg.win_y} + {1'b0, y_cell_r};
    xc         = {1'b0, cfg.win_x} + {1'b0, cx};
    ylim       = {1'b0, cfg.win_y} + {1'b0, cfg.win_h};
    if ({1'b0, cfg.scr_h} < ylim) begin
      ylim = {1'b0, cfg.scr_h};
    end
    xlim       = {1'b0, cfg.win_x} + {1'b0, cfg.win_w};
    if ({1'b0, cfg.scr_w} < xlim) begin
      xlim = {1'b0, cfg.scr_w};
    end
    prod       = 20'({yy, 3'b000}) * 20'(cfg.stride);
    mask_eff   = (mask == 8'h00) ? BLANK_MASK : mask;
    ls         = lead_shift(mask_eff);
    tz         = trail_zeros(mask_eff);
    width_base = 4'd8 - {1'b0, ls} - {1'b0, tz};
    mask_b     = bold_r ? smear(mask_eff) : mask_eff;
    sh_next    = 4'd8 - {1'b0, rs} + {1'b0, ls};
    mw_next    = ~({8'h00, mask_b} << sh_next);
    p          = bold_r ? smear(rdata) : rdata;
    pw         = {8'h00, p} << sh;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      row          <= 3'd0;
      result_valid <= 1'b0;
    end else begin
      result_valid <= 1'b0;
      case (state)
        ST_MASK: row <= row + 3'd1;
        ST_EMIT_L: begin
          result_valid <= 1'b1;
          if (rs == 3'd0) begin
            row <= row + 3'd1;
          end
        end
        ST_EMIT_R: begin
          result_valid <= 1'b1;
          row          <= row + 3'd1;
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      ST_IDLE: begin
        if (draw_acc) begin
          base     <= code_in_range(char_code) ? glyph_index(char_code)
                                               : glyph_index(CODE_DOT);
          rs       <= x_pixel[2:0];
          cx       <= x_pixel[10:3];
          y_cell_r <= y_cell;
          bold_r   <= bold;
          mask     <= 8'h00;
        end
      end
      ST_MASK: begin
        if (row != 3'd0) begin
          mask <= mask | rdata;
        end
      end
      ST_MASK_WAIT: begin
        mask     <= mask | rdata;
        row_addr <= prod[ADDR_BITS-1:0] + ADDR_BITS'(xc);
        left_ok  <= (yy < ylim) && (xc < xlim);
        right_ok <= (yy < ylim) && (({1'b0, xc} + 10'd1) < {1'b0, xlim});
      end
      ST_SHAPE: begin
        width <= width_base + {3'b000, bold_r};
        sh    <= sh_next;
        mw    <= mw_next;
      end
      ST_EMIT_L: begin
        write_enable <= left_ok;
        byte_address <= left_ok ? row_addr : '0;
        and_mask     <= left_ok ? mw[15:8] : 8'h00;
        or_bits      <= left_ok ? pw[15:8] : 8'h00;
        glyph_width  <= width;
        last         <= (rs == 3'd0) && (row == 3'd7);
        right_or     <= pw[7:0];
        if (rs == 3'd0) begin
          row_addr <= row_addr + ADDR_BITS'(cfg.stride);
        end
      end
      ST_EMIT_R: begin
        write_enable <= right_ok;
        byte_address <= right_ok ? (row_addr + ADDR_BITS'(1)) : '0;
        and_mask     <= right_ok ? mw[7:0] : 8'h00;
        or_bits      <= right_ok ? right_or : 8'h00;
        glyph_width  <= width;
        last         <= (row == 3'd7);
        row_addr     <= row_addr + ADDR_BITS'(cfg.stride);
      end
      default: begin
      end
    endcase
  end

  `PGB_ASSERT_NXT(a_last_gap, result_valid && last, !result_valid,
                  "item result follows its last result")
  `PGB_ASSERT_IMP(a_right_unaligned, state == ST_EMIT_R, rs != 3'd0,
                  "right cell emitted for aligned column")
  `PGB_ASSERT_IMP(a_idle_row, !busy, row == 3'd0,
                  "row counter not rewound at idle")
  `PGB_ASSERT_NXT(a_draw_enters, draw_acc, state == ST_MASK,
                  "accepted draw did not start mask reads")

endmodule

### rtl/proportional_glyph_blitter.sv
// Draw item: busy through mask reads, shaping and emission; yields 8 results (aligned)
// or 16 results (unaligned). A new item is accepted only while busy is low.
// Bound by the single font RAM read port: the 8 glyph rows are read for the mask, then
// again for emission. Font load: written on the accepting edge. Results cannot be stalled.
// Reset clears control state and loads register defaults; font RAM is undefined until
// loaded and gets no clearing pass.
module proportional_glyph_blitter import pgb_pkg::*; #(
  parameter int ADDR_BITS = PGB_ADDR_BITS
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 start,
  output logic                 busy,
  input  logic                 req_type,
  input  logic [7:0]           char_code,
  input  logic [2:0]           glyph_row,
  input  logic [7:0]           row_bits,
  input  logic [10:0]          x_pixel,
  input  logic [7:0]           y_cell,
  input  logic                 bold,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [2:0]           cfg_index,
  input  logic [7:0]           cfg_data,
  output logic                 result_valid,
  output logic                 write_enable,
  output logic [ADDR_BITS-1:0] byte_address,
  output logic [7:0]           and_mask,
  output logic [7:0]           or_bits,
  output logic [3:0]           glyph_width,
  output logic                 last
);

  pgb_cfg_t           cfg;
  logic               font_we;
  logic [FONT_AW-1:0] font_waddr;
  logic [FONT_AW-1:0] font_raddr;
  logic [7:0]         font_rdata;

  assign font_we    = start && !busy && (req_type == REQ_LOAD) && code_in_range(char_code);
  assign font_waddr = {glyph_index(char_code), glyph_row};

  pgb_regs u_regs (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  pgb_ram #(
    .WIDTH (8),
    .DEPTH (FONT_DEPTH)
  ) u_font (
    .clk   (clk),
    .we    (font_we),
    .waddr (font_waddr),
    .wdata (row_bits),
    .raddr (font_raddr),
    .rdata (font_rdata)
  );

  pgb_engine #(
    .ADDR_BITS (ADDR_BITS)
  ) u_engine (
    .clk          (clk),
    .rst          (rst),
    .start        (start),
    .req_type     (req_type),
    .char_code    (char_code),
    .x_pixel      (x_pixel),
    .y_cell       (y_cell),
    .bold         (bold),
    .cfg          (cfg),
    .rdata        (font_rdata),
    .raddr        (font_raddr),
    .busy         (busy),
    .result_valid (result_valid),
    .write_enable (write_enable),
    .byte_address (byte_address),
    .and_mask     (and_mask),
    .or_bits      (or_bits),
    .glyph_width  (glyph_width),
    .last         (last)
  );

endmodule
